/* rtl/pmfb_pkg.sv */
// Shared constants, command codes and payload types for the paged frame buffer.
`default_nettype none

package pmfb_pkg;

  // Geometry of the store.
  localparam int COLUMNS     = 128;
  localparam int PAGES       = 8;
  localparam int FRAMES      = 2;

  // One memory word holds eight neighboring column bytes of one page.
  localparam int GROUPS      = (COLUMNS + 7) / 8;
  localparam int FRAME_WORDS = PAGES * GROUPS;
  localparam int MEM_WORDS   = FRAMES * FRAME_WORDS;
  localparam int ADDR_W      = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int GROUP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;

  // Command codes.
  localparam logic [2:0] OP_CLEAR_FRAME = 3'd0;
  localparam logic [2:0] OP_SET_PIXEL   = 3'd1;
  localparam logic [2:0] OP_CLEAR_PIXEL = 3'd2;
  localparam logic [2:0] OP_READ_PIXEL  = 3'd3;
  localparam logic [2:0] OP_WRITE_BYTE  = 3'd4;
  localparam logic [2:0] OP_REFRESH     = 3'd5;

  // Result kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_GROUP = 1'b1;

  typedef struct packed {
    logic [2:0] op;
    logic [6:0] x_column;
    logic [5:0] y_row;
    logic [2:0] page_index;
    logic [7:0] byte_value;
    logic       frame_select;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic        pixel_state;
    logic [2:0]  out_page;
    logic [6:0]  first_column;
    logic [63:0] column_bytes;
    logic        last;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/paged_mono_frame_buffer.sv */
// Paged monochrome frame buffer: command decode, word store and refresh sequencer.
// Set, clear and write byte read the word, then modify it and write it back.
// A pixel read's reply is registered and waits for rsp_ready.
// A refresh reads each group of one page and then transfers it (one read, one transfer).
// A frame clear writes every store word of the frame.
// After reset a clearing pass writes every store word, MEM_WORDS words (256 by default).
`default_nettype none

module paged_mono_frame_buffer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire pmfb_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output pmfb_pkg::rsp_t     rsp
);
  import pmfb_pkg::*;

  localparam logic [2:0] ST_SWEEP   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_MODIFY  = 3'd2;
  localparam logic [2:0] ST_READ    = 3'd3;
  localparam logic [2:0] ST_REF_RD  = 3'd4;
  localparam logic [2:0] ST_REF_OUT = 3'd5;

  logic [2:0]         state;
  logic [ADDR_W-1:0]  sweep_addr;
  logic [ADDR_W-1:0]  sweep_end;
  logic [PAGE_W-1:0]  refresh_page;
  logic [GROUP_W-1:0] group;
  cmd_t               cmd_q;
  logic               hit_q;
  logic [ADDR_W-1:0]  addr_q;

  logic [63:0]        store [MEM_WORDS];
  logic [63:0]        rd_data;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [63:0]        mem_wdata;

  logic               accept;
  logic               slot_free;
  logic               rsp_load;
  logic               cmd_frame_ok;
  logic [3:0]         cmd_page;
  logic               cmd_hit;
  logic [ADDR_W-1:0]  cmd_addr;
  logic [ADDR_W-1:0]  frame_base;
  logic [ADDR_W-1:0]  ref_addr;
  logic               ref_frame_ok;
  logic               group_last;
  logic [2:0]         lane;
  logic [7:0]         lane_byte;
  logic [7:0]         bit_mask;
  logic [7:0]         new_byte;
  logic [63:0]        mod_word;

  // Word address of a frame, page and group of eight columns.
  function automatic logic [ADDR_W-1:0] word_addr(input logic frame, input int page,
                                                  input int grp);
    return ADDR_W'(int'(frame) * FRAME_WORDS + page * GROUPS + grp);
  endfunction

  assign cmd_ready = (state == ST_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign slot_free = !rsp_valid || rsp_ready;
  assign rsp_load  = slot_free && ((state == ST_READ) || (state == ST_REF_OUT));

  // Decode of the incoming command's address; pixel ops take the page from the row.
  always_comb begin
    cmd_frame_ok = int'(cmd.frame_select) < FRAMES;
    if (cmd.op == OP_WRITE_BYTE) begin
      cmd_page = {1'b0, cmd.page_index};
    end else begin
      cmd_page = {1'b0, cmd.y_row[5:3]};
    end
    cmd_hit    = cmd_frame_ok && (int'(cmd_page) < PAGES) && (int'(cmd.x_column) < COLUMNS);
    cmd_addr   = word_addr(cmd.frame_select, int'(cmd_page), int'(cmd.x_column[6:3]));
    frame_base = word_addr(cmd.frame_select, 0, 0);
  end

  // Refresh addressing.
  assign ref_addr     = word_addr(cmd_q.frame_select, int'(refresh_page), int'(group));
  assign ref_frame_ok = int'(cmd_q.frame_select) < FRAMES;
  assign group_last   = (group == GROUP_W'(GROUPS - 1));

  // Byte lane update for the pixel and byte commands.
  always_comb begin
    lane      = cmd_q.x_column[2:0];
    lane_byte = rd_data[{lane, 3'b000} +: 8];
    bit_mask  = 8'b1 << cmd_q.y_row[2:0];
    unique case (cmd_q.op)
      OP_SET_PIXEL:   new_byte = lane_byte | bit_mask;
      OP_CLEAR_PIXEL: new_byte = lane_byte & ~bit_mask;
      default:        new_byte = cmd_q.byte_value;
    endcase
    mod_word = rd_data;
    mod_word[{lane, 3'b000} +: 8] = new_byte;
  end

  // Memory port control.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = cmd_addr;
    if (accept) begin
      mem_re = 1'b1;
    end else if (state == ST_REF_RD) begin
      mem_re    = 1'b1;
      mem_raddr = ref_addr;
    end
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = mod_word;
    if (state == ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr;
      mem_wdata = '0;
    end else if (state == ST_MODIFY) begin
      mem_we = 1'b1;
    end
  end

  // Word store with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= store[mem_raddr];
    end
  end

  // Command sequencer and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      sweep_addr   <= '0;
      sweep_end    <= ADDR_W'(MEM_WORDS - 1);
      refresh_page <= '0;
      group        <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_SWEEP: begin
          if (sweep_addr == sweep_end) begin
            state <= ST_IDLE;
          end else begin
            sweep_addr <= sweep_addr + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_q  <= cmd;
            hit_q  <= cmd_hit;
            addr_q <= cmd_addr;
            unique case (cmd.op)
              OP_CLEAR_FRAME: begin
                if (cmd_frame_ok) begin
                  sweep_addr <= frame_base;
                  sweep_end  <= frame_base + ADDR_W'(FRAME_WORDS - 1);
                  state      <= ST_SWEEP;
                end
              end
              OP_SET_PIXEL, OP_CLEAR_PIXEL, OP_WRITE_BYTE: begin
                if (cmd_hit) begin
                  state <= ST_MODIFY;
                end
              end
              OP_READ_PIXEL: begin
                state <= ST_READ;
              end
              OP_REFRESH: begin
                group <= '0;
                state <= ST_REF_RD;
              end
              default: begin
              end
            endcase
          end
        end
        ST_MODIFY: begin
          state <= ST_IDLE;
        end
        ST_READ: begin
          if (slot_free) begin
            rsp_valid            <= 1'b1;
            rsp.kind             <= KIND_PIXEL;
            rsp.pixel_state      <= hit_q && lane_byte[cmd_q.y_row[2:0]];
            rsp.out_page         <= '0;
            rsp.first_column     <= '0;
            rsp.column_bytes     <= '0;
            rsp.last             <= 1'b1;
            state                <= ST_IDLE;
          end
        end
        ST_REF_RD: begin
          state <= ST_REF_OUT;
        end
        ST_REF_OUT: begin
          if (slot_free) begin
            rsp_valid        <= 1'b1;
            rsp.kind         <= KIND_GROUP;
            rsp.pixel_state  <= 1'b0;
            rsp.out_page     <= 3'(refresh_page);
            rsp.first_column <= 7'({group, 3'b000});
            rsp.column_bytes <= ref_frame_ok ? rd_data : 64'd0;
            rsp.last         <= group_last;
            if (group_last) begin
              if (refresh_page == PAGE_W'(PAGES - 1)) begin
                refresh_page <= '0;
              end else begin
                refresh_page <= refresh_page + PAGE_W'(1);
              end
              state <= ST_IDLE;
            end else begin
              group <= group + GROUP_W'(1);
              state <= ST_REF_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
